[hdl/tpc_pkg.sv]
package tpc_pkg;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_ONE  = 2'd1,
    KIND_TWO  = 2'd2,
    KIND_ALL  = 2'd3
  } kind_e;

  localparam logic [2:0] REG_PPX  = 3'd0;
  localparam logic [2:0] REG_PPY  = 3'd1;
  localparam logic [2:0] REG_PPZ  = 3'd2;
  localparam logic [2:0] REG_PNX  = 3'd3;
  localparam logic [2:0] REG_PNY  = 3'd4;
  localparam logic [2:0] REG_PNZ  = 3'd5;
  localparam logic [2:0] REG_SHOW = 3'd6;

  localparam logic [15:0] COL_BLUE  = 16'h0001;
  localparam logic [15:0] COL_GREEN = 16'h0002;
  localparam logic [15:0] COL_RED   = 16'h0004;

  // vertex indices, inside ones first, then outside, each in index order
  function automatic logic [5:0] order_of(input logic [2:0] ins);
    logic [5:0] r;
    logic [1:0] k;
    r = '0;
    k = '0;
    for (int i = 0; i < 3; i++) begin
      if (ins[i]) begin
        r[2*k +: 2] = 2'(i);
        k = k + 2'd1;
      end
    end
    for (int i = 0; i < 3; i++) begin
      if (!ins[i]) begin
        r[2*k +: 2] = 2'(i);
        k = k + 2'd1;
      end
    end
    return r;
  endfunction

  function automatic kind_e kind_of(input logic [2:0] ins);
    kind_e r;
    case (ins)
      3'b000:                         r = KIND_NONE;
      3'b001, 3'b010, 3'b100:         r = KIND_ONE;
      3'b011, 3'b101, 3'b110:         r = KIND_TWO;
      default:                        r = KIND_ALL;
    endcase
    return r;
  endfunction

endpackage

[hdl/triangle_plane_clipper.sv]
// Channel  | Dir | Handshake                      | Payload
// s_axis   | in  | s_axis_tvalid / s_axis_tready  | triangle: 9 coords, colour, glyph
// m_axis   | out | m_axis_tvalid / m_axis_tready  | result triangle, tlast on final one
// apb      | in  | psel, penable, pwrite, pready  | plane point, normal, show flag
//
// An accepted item passes stages 1 to 4, the divider stages, stage 5 and the output register.
// One item per cycle for items giving one triangle, while m_axis is ready; two-triangle
// items hold the pipe while their second triangle goes out, one triangle per cycle.
// The divider is one restoring step per stage, FRAC_BITS stages, two in parallel.
// Reset clears all valid bits and loads the register reset values.
// A stall on m_axis freezes every stage together; nothing is lost or repeated.
module triangle_plane_clipper #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16,
  localparam int TDW = ((9 * COORD_WIDTH + 32 + 7) / 8) * 8,
  localparam int PW  = (COORD_WIDTH > 32) ? 64 : 32,
  localparam int AS  = (COORD_WIDTH > 32) ? 3 : 2,
  localparam int AW  = AS + 3
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_axis_tvalid,
  output logic           s_axis_tready,
  // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, colour, glyph
  input  logic [TDW-1:0] s_axis_tdata,
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  // out0_x, out0_y, out0_z, out1_x, ... out2_z, out_colour, out_glyph
  output logic [TDW-1:0] m_axis_tdata,
  output logic           m_axis_tlast,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [AW-1:0]  paddr,
  input  logic [PW-1:0]  pwdata,
  output logic [PW-1:0]  prdata,
  output logic           pready
);

  localparam int CW  = COORD_WIDTH;
  localparam int FB  = FRAC_BITS;
  localparam int P2W = 2 * CW + 1;
  localparam int DW  = 2 * CW + 3;
  localparam int RW  = DW + 2;
  localparam int MW  = CW + FB + 2;
  localparam int SW  = CW + 3;

  typedef logic [2:0][CW-1:0] vec_t;
  typedef logic [2:0][CW:0]   dif_t;

  typedef struct packed {
    tpc_pkg::kind_e         kind;
    vec_t [2:0]             ord;
    dif_t [1:0]             dif;
    logic [1:0][RW-1:0]     rem;
    logic [1:0][RW-1:0]     den;
    logic [1:0][FB-1:0]     t;
    logic [15:0]            col;
    logic [15:0]            gly;
  } dv_t;

  // configuration
  logic [2:0][CW-1:0] pp_q, pn_q;
  logic               show_q;
  logic [2:0]         ridx;
  logic               adv;

  assign pready = 1'b1;
  assign ridx   = paddr[AW-1:AS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pp_q   <= '0;
      pn_q   <= {CW'(65536), CW'(0), CW'(0)};
      show_q <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (ridx)
        tpc_pkg::REG_PPX:  pp_q[0] <= pwdata[CW-1:0];
        tpc_pkg::REG_PPY:  pp_q[1] <= pwdata[CW-1:0];
        tpc_pkg::REG_PPZ:  pp_q[2] <= pwdata[CW-1:0];
        tpc_pkg::REG_PNX:  pn_q[0] <= pwdata[CW-1:0];
        tpc_pkg::REG_PNY:  pn_q[1] <= pwdata[CW-1:0];
        tpc_pkg::REG_PNZ:  pn_q[2] <= pwdata[CW-1:0];
        tpc_pkg::REG_SHOW: show_q  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      tpc_pkg::REG_PPX:  prdata = PW'($signed(pp_q[0]));
      tpc_pkg::REG_PPY:  prdata = PW'($signed(pp_q[1]));
      tpc_pkg::REG_PPZ:  prdata = PW'($signed(pp_q[2]));
      tpc_pkg::REG_PNX:  prdata = PW'($signed(pn_q[0]));
      tpc_pkg::REG_PNY:  prdata = PW'($signed(pn_q[1]));
      tpc_pkg::REG_PNZ:  prdata = PW'($signed(pn_q[2]));
      tpc_pkg::REG_SHOW: prdata = PW'(show_q);
      default:           prdata = '0;
    endcase
  end

  // stage 1: capture, v - p
  logic             s1_v_q;
  vec_t [2:0]       s1_vert_q;
  dif_t [2:0]       s1_dif_q;
  logic [15:0]      s1_col_q, s1_gly_q;
  vec_t [2:0]       s1_vert_d;
  dif_t [2:0]       s1_dif_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        s1_vert_d[i][j] = s_axis_tdata[(3*i+j)*CW +: CW];
        s1_dif_d[i][j]  = {s1_vert_d[i][j][CW-1], s1_vert_d[i][j]} -
                          {pp_q[j][CW-1], pp_q[j]};
      end
    end
  end

  // stage 2: products n * (v - p)
  logic                   s2_v_q;
  vec_t [2:0]             s2_vert_q;
  logic [2:0][2:0][P2W-1:0] s2_prod_q, s2_prod_d;
  logic [15:0]            s2_col_q, s2_gly_q;

  always_comb begin
    logic signed [P2W-1:0] ea, eb;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        ea = $signed(pn_q[j]);
        eb = $signed(s1_dif_q[i][j]);
        s2_prod_d[i][j] = ea * eb;
      end
    end
  end

  // stage 3: signed distances
  logic                   s3_v_q;
  vec_t [2:0]             s3_vert_q;
  logic [2:0][DW-1:0]     s3_dist_q, s3_dist_d;
  logic [15:0]            s3_col_q, s3_gly_q;

  always_comb begin
    logic signed [DW-1:0] a0, a1, a2;
    for (int i = 0; i < 3; i++) begin
      a0 = $signed(s2_prod_q[i][0]);
      a1 = $signed(s2_prod_q[i][1]);
      a2 = $signed(s2_prod_q[i][2]);
      s3_dist_d[i] = a0 + a1 + a2;
    end
  end

  // stage 4: ordering, divider setup
  logic [2:0]     ins;
  logic [5:0]     ordi;
  dv_t            dv0_d;

  always_comb begin
    logic [1:0] o0, o1, o2, pa0, pb0, pa1, pb1;
    logic signed [DW:0] da, db;
    for (int i = 0; i < 3; i++) begin
      ins[i] = !s3_dist_q[i][DW-1];
    end
    ordi = tpc_pkg::order_of(ins);
    o0 = ordi[1:0];
    o1 = ordi[3:2];
    o2 = ordi[5:4];
    dv0_d.kind = tpc_pkg::kind_of(ins);
    dv0_d.ord[0] = s3_vert_q[o0];
    dv0_d.ord[1] = s3_vert_q[o1];
    dv0_d.ord[2] = s3_vert_q[o2];
    pa0 = o0;
    pb0 = (dv0_d.kind == tpc_pkg::KIND_ONE) ? o1 : o2;
    pa1 = (dv0_d.kind == tpc_pkg::KIND_ONE) ? o0 : o1;
    pb1 = o2;
    for (int j = 0; j < 3; j++) begin
      dv0_d.dif[0][j] = {s3_vert_q[pb0][j][CW-1], s3_vert_q[pb0][j]} -
                        {s3_vert_q[pa0][j][CW-1], s3_vert_q[pa0][j]};
      dv0_d.dif[1][j] = {s3_vert_q[pb1][j][CW-1], s3_vert_q[pb1][j]} -
                        {s3_vert_q[pa1][j][CW-1], s3_vert_q[pa1][j]};
    end
    da = $signed(s3_dist_q[pa0]);
    db = $signed(s3_dist_q[pb0]);
    dv0_d.den[0] = RW'(da - db);
    dv0_d.rem[0] = RW'(s3_dist_q[pa0]);
    da = $signed(s3_dist_q[pa1]);
    db = $signed(s3_dist_q[pb1]);
    dv0_d.den[1] = RW'(da - db);
    dv0_d.rem[1] = RW'(s3_dist_q[pa1]);
    dv0_d.t   = '0;
    dv0_d.col = s3_col_q;
    dv0_d.gly = s3_gly_q;
  end

  // divider stages, one quotient bit each
  logic [FB:0] dv_v_q;
  dv_t         dv_q [0:FB];

  for (genvar k = 0; k < FB; k++) begin : g_div
    dv_t nxt;
    always_comb begin
      logic [RW-1:0] r2;
      nxt = dv_q[k];
      for (int j = 0; j < 2; j++) begin
        r2 = {dv_q[k].rem[j][RW-2:0], 1'b0};
        if (r2 >= dv_q[k].den[j]) begin
          nxt.rem[j] = r2 - dv_q[k].den[j];
          nxt.t[j]   = {dv_q[k].t[j][FB-2:0], 1'b1};
        end else begin
          nxt.rem[j] = r2;
          nxt.t[j]   = {dv_q[k].t[j][FB-2:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_q[k+1] <= nxt;
      end
    end
  end

  // stage 5: (b - a) * t
  logic                     s5_v_q;
  tpc_pkg::kind_e           s5_kind_q;
  vec_t [2:0]               s5_ord_q;
  vec_t [1:0]               s5_base_q, s5_base_d;
  logic [1:0][2:0][MW-1:0]  s5_mul_q, s5_mul_d;
  logic [15:0]              s5_col_q, s5_gly_q;

  always_comb begin
    logic signed [MW-1:0] ea, eb;
    s5_base_d[0] = dv_q[FB].ord[0];
    s5_base_d[1] = (dv_q[FB].kind == tpc_pkg::KIND_ONE) ? dv_q[FB].ord[0] : dv_q[FB].ord[1];
    for (int n = 0; n < 2; n++) begin
      for (int j = 0; j < 3; j++) begin
        ea = $signed(dv_q[FB].dif[n][j]);
        eb = $signed({1'b0, dv_q[FB].t[n]});
        s5_mul_d[n][j] = ea * eb;
      end
    end
  end

  // output stage: add, saturate, emit one or two triangles
  logic                 out_v_q, out_ph_q, out_last;
  tpc_pkg::kind_e       out_kind_q;
  vec_t [2:0]           out_ord_q;
  vec_t [1:0]           out_x_q, out_x_d;
  logic [15:0]          out_col_q, out_gly_q;

  always_comb begin
    logic signed [SW-1:0] sa, sd, sum, smax, smin;
    smax = $signed({3'b000, 1'b0, {(CW-1){1'b1}}});
    smin = -smax - SW'(1);
    for (int n = 0; n < 2; n++) begin
      for (int j = 0; j < 3; j++) begin
        sa  = $signed(s5_base_q[n][j]);
        sd  = $signed(s5_mul_q[n][j][MW-1:FB]);
        sum = sa + sd;
        if (sum > smax) begin
          out_x_d[n][j] = smax[CW-1:0];
        end else if (sum < smin) begin
          out_x_d[n][j] = smin[CW-1:0];
        end else begin
          out_x_d[n][j] = sum[CW-1:0];
        end
      end
    end
  end

  assign out_last = (out_kind_q != tpc_pkg::KIND_TWO) || out_ph_q;
  assign adv      = !out_v_q || (m_axis_tready && out_last);
  assign s_axis_tready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q   <= 1'b0;
      s2_v_q   <= 1'b0;
      s3_v_q   <= 1'b0;
      dv_v_q   <= '0;
      s5_v_q   <= 1'b0;
      out_v_q  <= 1'b0;
      out_ph_q <= 1'b0;
    end else if (adv) begin
      s1_v_q   <= s_axis_tvalid;
      s2_v_q   <= s1_v_q;
      s3_v_q   <= s2_v_q;
      dv_v_q   <= {dv_v_q[FB-1:0], s3_v_q && (dv0_d.kind != tpc_pkg::KIND_NONE)};
      s5_v_q   <= dv_v_q[FB];
      out_v_q  <= s5_v_q;
      out_ph_q <= 1'b0;
    end else if (m_axis_tready) begin
      out_ph_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_vert_q <= s1_vert_d;
      s1_dif_q  <= s1_dif_d;
      s1_col_q  <= s_axis_tdata[9*CW +: 16];
      s1_gly_q  <= s_axis_tdata[9*CW+16 +: 16];
      s2_vert_q <= s1_vert_q;
      s2_prod_q <= s2_prod_d;
      s2_col_q  <= s1_col_q;
      s2_gly_q  <= s1_gly_q;
      s3_vert_q <= s2_vert_q;
      s3_dist_q <= s3_dist_d;
      s3_col_q  <= s2_col_q;
      s3_gly_q  <= s2_gly_q;
      dv_q[0]   <= dv0_d;
      s5_kind_q <= dv_q[FB].kind;
      s5_ord_q  <= dv_q[FB].ord;
      s5_base_q <= s5_base_d;
      s5_mul_q  <= s5_mul_d;
      s5_col_q  <= dv_q[FB].col;
      s5_gly_q  <= dv_q[FB].gly;
      out_kind_q <= s5_kind_q;
      out_ord_q  <= s5_ord_q;
      out_x_q    <= out_x_d;
      out_col_q  <= s5_col_q;
      out_gly_q  <= s5_gly_q;
    end
  end

  vec_t [2:0]  tri_v;
  logic [15:0] tri_col;

  always_comb begin
    tri_v   = out_ord_q;
    tri_col = out_col_q;
    if (out_ph_q) begin
      tri_v   = '{out_x_q[1], out_x_q[0], out_ord_q[1]};
      tri_col = show_q ? tpc_pkg::COL_RED : out_col_q;
    end else begin
      case (out_kind_q)
        tpc_pkg::KIND_ONE: begin
          tri_v   = '{out_x_q[1], out_x_q[0], out_ord_q[0]};
          tri_col = show_q ? tpc_pkg::COL_BLUE : out_col_q;
        end
        tpc_pkg::KIND_TWO: begin
          tri_v   = '{out_x_q[0], out_ord_q[1], out_ord_q[0]};
          tri_col = show_q ? tpc_pkg::COL_GREEN : out_col_q;
        end
        default: begin
          tri_v   = out_ord_q;
          tri_col = out_col_q;
        end
      endcase
    end
    m_axis_tdata = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        m_axis_tdata[(3*i+j)*CW +: CW] = tri_v[i][j];
      end
    end
    m_axis_tdata[9*CW +: 16]    = tri_col;
    m_axis_tdata[9*CW+16 +: 16] = out_gly_q;
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tlast  = out_last;

  a_phase_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ph_q |-> out_v_q && out_kind_q == tpc_pkg::KIND_TWO)
    else $error("second triangle phase without a two-triangle item");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !m_axis_tready |=> out_v_q && $stable(out_ph_q))
    else $error("output item lost under stall");

  a_no_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_v_q[0] |-> dv_q[0].kind != tpc_pkg::KIND_NONE)
    else $error("fully clipped item entered divider");

  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(dv_v_q) && $stable(s5_v_q))
    else $error("pipeline moved during stall");

endmodule
